>>> design/htok_pkg.sv
// htok_pkg: phase codes, part tags, delimiter bytes and the tracker state word
// shared by the classifier and the top level of the http request tokenizer
// no dependencies
package htok_pkg;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_TARGET,
        PH_VERSION,
        PH_NAME,
        PH_VALUE,
        PH_BODY
    } htok_phase_t;

    localparam logic [2:0] PART_DROP    = 3'd0;
    localparam logic [2:0] PART_METHOD  = 3'd1;
    localparam logic [2:0] PART_TARGET  = 3'd2;
    localparam logic [2:0] PART_VERSION = 3'd3;
    localparam logic [2:0] PART_NAME    = 3'd4;
    localparam logic [2:0] PART_VALUE   = 3'd5;
    localparam logic [2:0] PART_BODY    = 3'd6;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;

    localparam logic [3:0] VERSION_LEN = 4'd8;
    localparam logic [3:0] VERSION_POS_MAX = 4'd9;

    typedef struct packed {
        htok_phase_t phase;
        logic [3:0]  version_pos;
        logic        version_mismatch;
        logic        space_skip;
        logic        line_empty;
    } htok_state_t;

    localparam htok_state_t STATE_RESET = '{
        phase:            PH_METHOD,
        version_pos:      4'd0,
        version_mismatch: 1'b0,
        space_skip:       1'b0,
        line_empty:       1'b1
    };

    typedef struct packed {
        logic [2:0] part;
        logic       token_end;
        logic       close_header;
    } htok_tag_t;

    // expected text HTTP/1.1
    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2f;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2e;
            default: c = 8'h31;
        endcase
        return c;
    endfunction

endpackage

>>> design/htok_classify.sv
// htok_classify: tags one request byte and computes the next tracker state
// depends on htok_pkg
module htok_classify
    import htok_pkg::*;
(
    input  htok_state_t st,
    input  logic [7:0]  in_byte,
    output htok_state_t st_next,
    output htok_tag_t   tag
);

    always_comb
    begin
        st_next = st;
        tag     = '{part: PART_DROP, token_end: 1'b0, close_header: 1'b0};
        unique case (st.phase)
            PH_METHOD:
            begin
                if (in_byte == CH_SPACE)
                begin
                    tag.token_end = 1'b1;
                    st_next.phase = PH_TARGET;
                end
                else
                begin
                    tag.part = PART_METHOD;
                end
            end
            PH_TARGET:
            begin
                if (in_byte == CH_SPACE)
                begin
                    tag.token_end = 1'b1;
                    st_next.phase = PH_VERSION;
                end
                else
                begin
                    tag.part = PART_TARGET;
                end
            end
            PH_VERSION:
            begin
                if (in_byte == CH_CR)
                begin
                    tag.part = PART_DROP;
                end
                else if (in_byte == CH_LF)
                begin
                    tag.token_end = 1'b1;
                    if (st.version_pos != VERSION_LEN)
                    begin
                        st_next.version_mismatch = 1'b1;
                    end
                    st_next.phase      = PH_NAME;
                    st_next.line_empty = 1'b1;
                end
                else
                begin
                    tag.part = PART_VERSION;
                    if (st.version_pos < VERSION_LEN)
                    begin
                        if (in_byte != version_char(st.version_pos[2:0]))
                        begin
                            st_next.version_mismatch = 1'b1;
                        end
                    end
                    else
                    begin
                        st_next.version_mismatch = 1'b1;
                    end
                    if (st.version_pos < VERSION_POS_MAX)
                    begin
                        st_next.version_pos = st.version_pos + 4'd1;
                    end
                end
            end
            PH_NAME:
            begin
                if (in_byte == CH_CR)
                begin
                    tag.part = PART_DROP;
                end
                else if (in_byte == CH_LF)
                begin
                    if (st.line_empty)
                    begin
                        st_next.phase = PH_BODY;
                    end
                    else
                    begin
                        tag.token_end      = 1'b1;
                        tag.close_header   = 1'b1;
                        st_next.line_empty = 1'b1;
                    end
                end
                else if (in_byte == CH_COLON)
                begin
                    tag.token_end      = 1'b1;
                    st_next.phase      = PH_VALUE;
                    st_next.space_skip = 1'b1;
                    st_next.line_empty = 1'b0;
                end
                else
                begin
                    tag.part           = PART_NAME;
                    st_next.line_empty = 1'b0;
                end
            end
            PH_VALUE:
            begin
                st_next.space_skip = 1'b0;
                if (st.space_skip && in_byte == CH_SPACE)
                begin
                    tag.part = PART_DROP;
                end
                else if (in_byte == CH_CR)
                begin
                    tag.part = PART_DROP;
                end
                else if (in_byte == CH_LF)
                begin
                    tag.token_end      = 1'b1;
                    tag.close_header   = 1'b1;
                    st_next.phase      = PH_NAME;
                    st_next.line_empty = 1'b1;
                end
                else
                begin
                    tag.part = PART_VALUE;
                end
            end
            PH_BODY:
            begin
                tag.part = PART_BODY;
            end
            default:
            begin
                tag.part = PART_BODY;
            end
        endcase
    end

endmodule

>>> design/http_request_tokenizer_top.sv
// http_request_tokenizer_top: byte tagger for http/1.1 requests with valid/stall ports
// depends on htok_pkg and htok_classify
// One word (a request byte) is accepted per clock unless in_stall is high, and yields
// exactly one tagged word. Throughput is one word per cycle while out_stall is low. A word
// accepted enters the input register, moves into the result register once that register is
// free or out_stall is low, and shows out_valid from then on. The rate is set by the loop
// through the phase tracker and header counter, updated as each word moves from
// the input register into the result register. A word marked last returns all state
// to reset. header_number is the header count before the word, saturating at
// MAX_HEADERS and showing its low five bits.
module http_request_tokenizer_top
    import htok_pkg::*;
#(
    parameter int MAX_HEADERS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [2:0] part,
    output logic [4:0] header_number,
    output logic       token_end,
    output logic       version_bad,
    output logic       header_overflow,
    output logic       out_last
);

    localparam int CW = $clog2(MAX_HEADERS + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_HEADERS);

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_last_reg;
    logic          s1_adv;
    logic          in_accept;

    htok_state_t   st_reg;
    htok_state_t   st_next;
    htok_tag_t     tag;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [CW+4:0] count_ext;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic [2:0]    part_reg;
    logic [4:0]    hnum_reg;
    logic          tend_reg;
    logic          vbad_reg;
    logic          ovf_out_reg;
    logic          last_reg;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    htok_classify u_classify (
        .st      (st_reg),
        .in_byte (s1_byte_reg),
        .st_next (st_next),
        .tag     (tag)
    );

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (tag.close_header)
        begin
            if (count_reg == COUNT_MAX)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    assign count_ext = {5'd0, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= STATE_RESET;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                st_reg    <= STATE_RESET;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                st_reg    <= st_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_byte_reg <= s1_byte_reg;
            part_reg     <= tag.part;
            hnum_reg     <= count_ext[4:0];
            tend_reg     <= tag.token_end;
            vbad_reg     <= st_next.version_mismatch;
            ovf_out_reg  <= ovf_next;
            last_reg     <= s1_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign part            = part_reg;
    assign header_number   = hnum_reg;
    assign token_end       = tend_reg;
    assign version_bad     = vbad_reg;
    assign header_overflow = ovf_out_reg;
    assign out_last        = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("header count beyond limit");

    a_tend_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && tend_reg |-> part_reg == PART_DROP)
        else $error("token end on a non-delimiter word");

    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ovf_out_reg |-> hnum_reg == 5'(MAX_HEADERS))
        else $error("overflow without saturated header number");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> st_reg == STATE_RESET && count_reg == '0 && !ovf_reg)
        else $error("state not cleared after last word");

endmodule

>>> tb/sv/http_request_tokenizer_top_tb.sv
// testbench for http_request_tokenizer_top: directed and random request streams
// checked word by word against a tag predictor kept in the testbench
// depends on htok_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module http_request_tokenizer_top_tb;
    import htok_pkg::*;

    localparam int HDR_LIMIT = 16;
    localparam logic [63:0] VER_TEXT = "HTTP/1.1";
    localparam int RANDOM_WORDS = 480;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] part;
        logic [4:0] hnum;
        logic       tend;
        logic       vbad;
        logic       ovf;
        logic       last;
    } tagged_word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } req_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'd0;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic [2:0] part;
    logic [4:0] header_number;
    logic       token_end;
    logic       version_bad;
    logic       header_overflow;
    logic       out_last;

    // tracker state of the predictor
    htok_phase_t tk_phase;
    int          ver_pos;
    logic        ver_bad;
    int          hdr_count;
    logic        hdr_ovf;
    logic        skip_space;
    logic        line_blank;

    tagged_word_t pending_tags[$];
    req_word_t    req_words[$];
    int           errors = 0;
    int           words_checked = 0;
    int           gap_max = 7;
    int           stall_max = 7;
    int           hold_cycles = 0;

    http_request_tokenizer_top #(
        .MAX_HEADERS(HDR_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .in_last(in_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .part(part),
        .header_number(header_number),
        .token_end(token_end),
        .version_bad(version_bad),
        .header_overflow(header_overflow),
        .out_last(out_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void reset_tracker();
        tk_phase = PH_METHOD;
        ver_pos = 0;
        ver_bad = 1'b0;
        hdr_count = 0;
        hdr_ovf = 1'b0;
        skip_space = 1'b0;
        line_blank = 1'b1;
    endfunction

    function automatic void count_header();
        if (hdr_count < HDR_LIMIT)
            hdr_count++;
        else
            hdr_ovf = 1'b1;
    endfunction

    function automatic tagged_word_t tag_byte(input logic [7:0] b, input logic last);
        tagged_word_t t;
        logic skip;
        t.data = b;
        t.part = PART_DROP;
        t.tend = 1'b0;
        t.hnum = 5'(hdr_count);
        case (tk_phase)
            PH_METHOD:
            begin
                if (b == CH_SPACE)
                begin
                    t.tend = 1'b1;
                    tk_phase = PH_TARGET;
                end
                else
                    t.part = PART_METHOD;
            end
            PH_TARGET:
            begin
                if (b == CH_SPACE)
                begin
                    t.tend = 1'b1;
                    tk_phase = PH_VERSION;
                end
                else
                    t.part = PART_TARGET;
            end
            PH_VERSION:
            begin
                if (b == CH_LF)
                begin
                    t.tend = 1'b1;
                    if (ver_pos != 8)
                        ver_bad = 1'b1;
                    tk_phase = PH_NAME;
                    line_blank = 1'b1;
                end
                else if (b != CH_CR)
                begin
                    t.part = PART_VERSION;
                    if (ver_pos >= 8 || b != VER_TEXT[63 - 8 * ver_pos -: 8])
                        ver_bad = 1'b1;
                    if (ver_pos < 9)
                        ver_pos++;
                end
            end
            PH_NAME:
            begin
                if (b == CH_LF)
                begin
                    if (line_blank)
                        tk_phase = PH_BODY;
                    else
                    begin
                        t.tend = 1'b1;
                        count_header();
                        line_blank = 1'b1;
                    end
                end
                else if (b == CH_COLON)
                begin
                    t.tend = 1'b1;
                    tk_phase = PH_VALUE;
                    skip_space = 1'b1;
                    line_blank = 1'b0;
                end
                else if (b != CH_CR)
                begin
                    t.part = PART_NAME;
                    line_blank = 1'b0;
                end
            end
            PH_VALUE:
            begin
                skip = skip_space;
                skip_space = 1'b0;
                if (b == CH_LF)
                begin
                    t.tend = 1'b1;
                    count_header();
                    tk_phase = PH_NAME;
                    line_blank = 1'b1;
                end
                else if (!(skip && b == CH_SPACE) && b != CH_CR)
                    t.part = PART_VALUE;
            end
            default:
                t.part = PART_BODY;
        endcase
        t.vbad = ver_bad;
        t.ovf = hdr_ovf;
        t.last = last;
        if (last)
            reset_tracker();
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns word %0d: %s", $realtime, words_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // sender: one word, accepted when valid is high and stall low at the edge
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_tags.push_back(tag_byte(b, last));
    endtask

    task automatic send_stream();
        foreach (req_words[i])
            send_word(req_words[i].data, req_words[i].last);
        in_valid <= 1'b0;
        @(posedge clk);
        req_words.delete();
    endtask

    function automatic void push_byte(input logic [7:0] b);
        req_words.push_back('{b, 1'b0});
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_byte(input logic [7:0] x1, input logic [7:0] x2,
                                             input logic [7:0] x3);
        logic [7:0] c;
        do
            c = 8'($urandom_range(255, 0));
        while (c == x1 || c == x2 || c == x3);
        return c;
    endfunction

    // request with random content, variable version and header count, some headers without colon
    function automatic void build_request();
        int n;
        int vmode;
        n = $urandom_range(6, 1);
        repeat (n) push_byte(pick_byte(CH_SPACE, CH_SPACE, CH_SPACE));
        push_byte(CH_SPACE);
        n = $urandom_range(8, 1);
        repeat (n) push_byte(pick_byte(CH_SPACE, CH_SPACE, CH_SPACE));
        push_byte(CH_SPACE);
        vmode = $urandom_range(7, 0);
        if (vmode == 0)
        begin
            n = $urandom_range(11, 0);
            repeat (n) push_byte(pick_byte(CH_CR, CH_LF, CH_LF));
        end
        else
        begin
            n = (vmode == 1) ? $urandom_range(7, 0) : 8;
            for (int i = 0; i < 8; i++)
                push_byte(i == n ? pick_byte(CH_CR, CH_LF, CH_LF) : VER_TEXT[63 - 8 * i -: 8]);
            if (vmode == 2)
                push_byte(pick_byte(CH_CR, CH_LF, CH_LF));
        end
        if ($urandom_range(1, 0))
            push_byte(CH_CR);
        push_byte(CH_LF);
        n = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 16) : $urandom_range(4, 0);
        repeat (n)
        begin
            repeat ($urandom_range(6, 1)) push_byte(pick_byte(CH_COLON, CH_CR, CH_LF));
            if ($urandom_range(7, 0) != 0)
            begin
                push_byte(CH_COLON);
                if ($urandom_range(3, 0) != 0)
                    push_byte(CH_SPACE);
                repeat ($urandom_range(6, 0)) push_byte(pick_byte(CH_CR, CH_LF, CH_LF));
            end
            if ($urandom_range(1, 0))
                push_byte(CH_CR);
            push_byte(CH_LF);
        end
        if ($urandom_range(1, 0))
            push_byte(CH_CR);
        push_byte(CH_LF);
        repeat ($urandom_range(8, 0)) push_byte(8'($urandom_range(255, 0)));
        req_words[$].last = 1'b1;
    endfunction

    task automatic test_full_request();
        push_text("M T HTTP/1.1");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_text("N: V");
        push_byte(CH_LF);
        push_byte(CH_LF);
        push_text("B:");
        push_byte(8'hff);
        req_words[$].last = 1'b1;
        send_stream();
    endtask

    // lf in method and target, short version, cr in version, header without colon
    task automatic test_odd_lines();
        push_byte(8'h00);
        push_byte(CH_LF);
        push_byte(CH_SPACE);
        push_byte(CH_LF);
        push_byte(CH_SPACE);
        push_text("H");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_text("x");
        push_byte(CH_LF);
        req_words[$].last = 1'b1;
        send_stream();
    endtask

    // long receiver hold while more headers than the limit stream in back to back
    task automatic test_backpressure_overflow();
        gap_max = 0;
        hold_cycles = 60;
        push_text("G / HTTP/1.1");
        push_byte(CH_LF);
        repeat (HDR_LIMIT + 2)
        begin
            push_text("k:v");
            push_byte(CH_LF);
        end
        push_byte(CH_LF);
        push_text("b");
        req_words[$].last = 1'b1;
        send_stream();
        gap_max = 7;
    endtask

    task automatic test_random_requests();
        int sent;
        int kind;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if ($urandom_range(3, 0) == 0)
            begin
                gap_max = 0;
                stall_max = 0;
            end
            else
            begin
                gap_max = 7;
                stall_max = 7;
            end
            kind = $urandom_range(9, 0);
            if (kind == 0)
            begin
                repeat ($urandom_range(12, 1))
                begin
                    push_byte(8'($urandom_range(255, 0)));
                    req_words[$].last = ($urandom_range(7, 0) == 0);
                end
                req_words[$].last = 1'b1;
            end
            else
            begin
                build_request();
                if (kind == 1)
                begin
                    kind = $urandom_range(req_words.size() - 1, 0);
                    while (req_words.size() > kind + 1)
                        void'(req_words.pop_back());
                    req_words[$].last = 1'b1;
                end
            end
            sent += req_words.size();
            send_stream();
        end
        gap_max = 7;
        stall_max = 7;
    endtask

    // receiver: random stall before each word, long hold when requested
    initial
    begin : tag_checker
        tagged_word_t got;
        tagged_word_t want;
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = $urandom_range(stall_max, 0);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got = '{out_byte, part, header_number, token_end, version_bad,
                    header_overflow, out_last};
            if (pending_tags.size() == 0)
                report_mismatch($sformatf("word with nothing pending, byte %0d", got.data));
            else
            begin
                want = pending_tags.pop_front();
                check_field("out_byte", got.data, want.data);
                check_field("part", 8'(got.part), 8'(want.part));
                check_field("header_number", 8'(got.hnum), 8'(want.hnum));
                check_field("token_end", 8'(got.tend), 8'(want.tend));
                check_field("version_bad", 8'(got.vbad), 8'(want.vbad));
                check_field("header_overflow", 8'(got.ovf), 8'(want.ovf));
                check_field("out_last", 8'(got.last), 8'(want.last));
            end
            words_checked++;
        end
    end

    initial
    begin
        reset_tracker();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_full_request();
        test_odd_lines();
        test_backpressure_overflow();
        test_random_requests();
        while (pending_tags.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("http_request_tokenizer_top_tb: clean");
        else
            $display("http_request_tokenizer_top_tb: errors");
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("timeout with %0d words pending", pending_tags.size());
        $display("http_request_tokenizer_top_tb: errors");
        $finish;
    end

endmodule
